// File: hdl/e2dd_pkg.sv
// Package for the epoch-to-DOS date/time converter.
// Holds the divisor constants, their reciprocals and the month start table.
// No dependencies.
package e2dd_pkg;

	// Seconds in a day are 2^7 * 675: the low seven bits pass straight through.
	localparam logic [9:0]  DAY_DIV      = 10'd675;
	// Reciprocal of 675 scaled by 2^35, rounded up: exact for 25-bit dividends.
	localparam logic [25:0] DAY_RECIP    = 26'd50903317;
	localparam int          DAY_SHIFT    = 35;

	// Day number 1970-01-01 counted from 0000-03-01.
	localparam logic [19:0] EPOCH_DAYS   = 20'd719468;
	// Days in one 400-year Gregorian cycle.
	localparam logic [19:0] ERA_DAYS     = 20'd146097;

	// Hour: (sod >> 4) / 225, reciprocal scaled by 2^21.
	localparam logic [13:0] HOUR_RECIP   = 14'd9321;
	localparam logic [16:0] SECS_PER_HR  = 17'd3600;

	// Minute: (rem >> 2) / 15, reciprocal scaled by 2^14.
	localparam logic [10:0] MIN_RECIP    = 11'd1093;
	localparam logic [11:0] SECS_PER_MIN = 12'd60;

	// Leap-day correction: (doe >> 2) / 365, reciprocal scaled by 2^25.
	localparam logic [16:0] Q1460_RECIP  = 17'd91930;
	localparam logic [17:0] CENT_DAYS    = 18'd36524;
	localparam logic [17:0] LAST_DOE     = 18'd146096;

	// Year of era: t / 365, reciprocal scaled by 2^27.
	localparam logic [18:0] YEAR_RECIP   = 19'd367720;
	localparam logic [17:0] DAYS_PER_YR  = 18'd365;

	// Month from day of year: (5 * doy + 2) / 153, reciprocal scaled by 2^19.
	localparam logic [11:0] MP_RECIP     = 12'd3427;

	localparam logic [11:0] YEARS_PER_ERA = 12'd400;
	localparam logic [11:0] DOS_BASE_YEAR = 12'd1980;

	// First day of each month, counted from March 1, as (153 * mp + 2) / 5.
	function automatic logic [8:0] month_start(input logic [3:0] mp);
		logic [8:0] r;
		unique case (mp)
			4'd0:    r = 9'd0;
			4'd1:    r = 9'd31;
			4'd2:    r = 9'd61;
			4'd3:    r = 9'd92;
			4'd4:    r = 9'd122;
			4'd5:    r = 9'd153;
			4'd6:    r = 9'd184;
			4'd7:    r = 9'd214;
			4'd8:    r = 9'd245;
			4'd9:    r = 9'd275;
			4'd10:   r = 9'd306;
			4'd11:   r = 9'd337;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

endpackage

// File: hdl/epoch_to_dos_datetime.sv
// Epoch seconds to packed DOS date and time words, nine-stage pipeline.
// Uses e2dd_pkg for divisor reciprocals and the month start table.
//
// Usage:
// The input channel (epoch_valid / epoch_stall) carries one 32-bit count of
// seconds since 1970-01-01 00:00:00 UTC per beat. The output channel
// (dos_valid / dos_stall) returns one beat per input beat, in order, with the
// DOS date word and DOS time word of that instant.
// Each accepted input beat passes through stage registers s1 to s9, in order,
// to its output beat. Throughput is one beat per cycle while the output is not
// stalled: each division is a constant reciprocal multiply or a compare chain.
// Each stage advances when it is empty or the stage after it advances, so
// empty slots close up while the output is stalled; epoch_stall rises only
// once all nine stages hold beats and dos_stall is high. A stalled output
// beat holds its value.
// Reset clears the stage valid bits only; the data registers are not reset.
module epoch_to_dos_datetime (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        epoch_valid,
	output logic        epoch_stall,
	input  logic [31:0] epoch_seconds,
	output logic        dos_valid,
	input  logic        dos_stall,
	output logic [15:0] dos_date,
	output logic [15:0] dos_time
);

	// Stage valid bits and advance enables.
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;
	logic adv1, adv2, adv3, adv4, adv5, adv6, adv7, adv8, adv9;

	assign adv9 = !v_s9 || !dos_stall;
	assign adv8 = !v_s8 || adv9;
	assign adv7 = !v_s7 || adv8;
	assign adv6 = !v_s6 || adv7;
	assign adv5 = !v_s5 || adv6;
	assign adv4 = !v_s4 || adv5;
	assign adv3 = !v_s3 || adv4;
	assign adv2 = !v_s2 || adv3;
	assign adv1 = !v_s1 || adv2;

	assign epoch_stall = !adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= epoch_valid;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
			if (adv4) v_s4 <= v_s3;
			if (adv5) v_s5 <= v_s4;
			if (adv6) v_s6 <= v_s5;
			if (adv7) v_s7 <= v_s6;
			if (adv8) v_s8 <= v_s7;
			if (adv9) v_s9 <= v_s8;
		end
	end

	// Pipeline data registers.
	logic [24:0] x_s1;
	logic [6:0]  lo_s1;
	logic [50:0] pday_s1;
	logic [15:0] days_s2;
	logic [16:0] sod_s2;
	logic [2:0]  era_s3, era_s4, era_s5, era_s6, era_s7, era_s8;
	logic [17:0] doe_s3, doe_s4, doe_s5, doe_s6;
	logic [26:0] hprod_s3;
	logic [16:0] sod_s3;
	logic [32:0] q1460_s4;
	logic [2:0]  b_s4;
	logic        c_s4;
	logic [4:0]  hour_s4, hour_s5;
	logic [11:0] hrem_s4, hrem_s5;
	logic [17:0] t_s5;
	logic [19:0] mprod_s5;
	logic [36:0] yprod_s6;
	logic [15:0] time_s6, time_s7, time_s8, time_s9;
	logic [8:0]  doy_s7, doy_s8;
	logic [8:0]  yoe_s7, yoe_s8;
	logic [22:0] mpprod_s8;
	logic [15:0] date_s9;

	// Stage 2: whole days and second of day.
	logic [15:0] days_c;
	logic [24:0] rday_c;
	assign days_c = pday_s1[50:e2dd_pkg::DAY_SHIFT];
	assign rday_c = x_s1 - 25'(days_c) * 25'(e2dd_pkg::DAY_DIV);

	// Stage 3: era and day of era; hour reciprocal product.
	logic [19:0] z_c;
	logic [2:0]  era_c;
	logic [17:0] doe_c;
	always_comb begin
		z_c   = 20'(days_s2) + e2dd_pkg::EPOCH_DAYS;
		era_c = 3'd0;
		if (z_c >= e2dd_pkg::ERA_DAYS)          era_c = 3'd1;
		if (z_c >= 20'(2 * 146097))             era_c = 3'd2;
		if (z_c >= 20'(3 * 146097))             era_c = 3'd3;
		if (z_c >= 20'(4 * 146097))             era_c = 3'd4;
		if (z_c >= 20'(5 * 146097))             era_c = 3'd5;
		doe_c = 18'(z_c - 20'(era_c) * e2dd_pkg::ERA_DAYS);
	end

	// Stage 4: leap-day correction terms; hour and remainder.
	logic [2:0]  b_c;
	logic [4:0]  hour_c;
	logic [16:0] hrem_c;
	always_comb begin
		b_c = 3'(doe_s3 >= e2dd_pkg::CENT_DAYS)
			+ 3'(doe_s3 >= 18'(2 * 36524))
			+ 3'(doe_s3 >= 18'(3 * 36524))
			+ 3'(doe_s3 >= e2dd_pkg::LAST_DOE);
		hour_c = hprod_s3[25:21];
		hrem_c = sod_s3 - 17'(hour_c) * e2dd_pkg::SECS_PER_HR;
	end

	// Stage 5: day count with leap days removed.
	logic [17:0] t_c;
	assign t_c = doe_s4 - 18'(q1460_s4[32:25]) + 18'(b_s4) - 18'(c_s4);

	// Stage 6: minute and half-seconds.
	logic [5:0]  minute_c;
	logic [11:0] sec_c;
	assign minute_c = mprod_s5[19:14];
	assign sec_c    = hrem_s5 - 12'(minute_c) * e2dd_pkg::SECS_PER_MIN;

	// Stage 7: year of era and day of year (from March 1).
	logic [8:0]  yoe_c;
	logic [1:0]  cent_c;
	logic [17:0] ybase_c;
	always_comb begin
		yoe_c   = yprod_s6[35:27];
		cent_c  = 2'(yoe_c >= 9'd100) + 2'(yoe_c >= 9'd200) + 2'(yoe_c >= 9'd300);
		ybase_c = 18'(yoe_c) * e2dd_pkg::DAYS_PER_YR + 18'(yoe_c[8:2]) - 18'(cent_c);
	end

	// Stage 8: month index numerator.
	logic [10:0] mpnum_c;
	assign mpnum_c = 11'(doy_s7) * 11'd5 + 11'd2;

	// Stage 9: month, day and year packed into the date word.
	logic [3:0]  mp_c;
	logic [3:0]  month_c;
	logic [8:0]  dsum_c;
	logic [11:0] year_c;
	logic [6:0]  yfield_c;
	always_comb begin
		mp_c     = mpprod_s8[22:19];
		dsum_c   = doy_s8 - e2dd_pkg::month_start(mp_c) + 9'd1;
		month_c  = (mp_c < 4'd10) ? mp_c + 4'd3 : mp_c - 4'd9;
		year_c   = 12'(yoe_s8) + 12'(era_s8) * e2dd_pkg::YEARS_PER_ERA
			+ 12'(month_c <= 4'd2);
		yfield_c = year_c[6:0] - e2dd_pkg::DOS_BASE_YEAR[6:0];
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			x_s1    <= epoch_seconds[31:7];
			lo_s1   <= epoch_seconds[6:0];
			pday_s1 <= 51'(epoch_seconds[31:7]) * 51'(e2dd_pkg::DAY_RECIP);
		end
		if (adv2) begin
			days_s2 <= days_c;
			sod_s2  <= {rday_c[9:0], lo_s1};
		end
		if (adv3) begin
			era_s3   <= era_c;
			doe_s3   <= doe_c;
			hprod_s3 <= 27'(sod_s2[16:4]) * 27'(e2dd_pkg::HOUR_RECIP);
			sod_s3   <= sod_s2;
		end
		if (adv4) begin
			q1460_s4 <= 33'(doe_s3[17:2]) * 33'(e2dd_pkg::Q1460_RECIP);
			b_s4     <= b_c;
			c_s4     <= (doe_s3 == e2dd_pkg::LAST_DOE);
			doe_s4   <= doe_s3;
			era_s4   <= era_s3;
			hour_s4  <= hour_c;
			hrem_s4  <= hrem_c[11:0];
		end
		if (adv5) begin
			t_s5     <= t_c;
			doe_s5   <= doe_s4;
			era_s5   <= era_s4;
			mprod_s5 <= 20'(hrem_s4[11:2]) * 20'(e2dd_pkg::MIN_RECIP);
			hour_s5  <= hour_s4;
			hrem_s5  <= hrem_s4;
		end
		if (adv6) begin
			yprod_s6 <= 37'(t_s5) * 37'(e2dd_pkg::YEAR_RECIP);
			doe_s6   <= doe_s5;
			era_s6   <= era_s5;
			time_s6  <= {hour_s5, minute_c, sec_c[5:1]};
		end
		if (adv7) begin
			doy_s7  <= 9'(doe_s6 - ybase_c);
			yoe_s7  <= yoe_c;
			era_s7  <= era_s6;
			time_s7 <= time_s6;
		end
		if (adv8) begin
			mpprod_s8 <= 23'(mpnum_c) * 23'(e2dd_pkg::MP_RECIP);
			doy_s8    <= doy_s7;
			yoe_s8    <= yoe_s7;
			era_s8    <= era_s7;
			time_s8   <= time_s7;
		end
		if (adv9) begin
			date_s9 <= {yfield_c, month_c, dsum_c[4:0]};
			time_s9 <= time_s8;
		end
	end

	assign dos_valid = v_s9;
	assign dos_date  = date_s9;
	assign dos_time  = time_s9;

`ifndef NO_ASSERTIONS
	// The input is held off only when every stage holds a beat and the output waits.
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		epoch_stall |-> (v_s1 && v_s2 && v_s3 && v_s4 && v_s5 && v_s6 && v_s7
			&& v_s8 && v_s9 && dos_stall))
		else $error("input stalled while the pipeline has an empty stage");

	// Every delivered date has a real month and a nonzero day.
	a_date_fields: assert property (@(posedge clk) disable iff (!arst_n)
		dos_valid |-> (dos_date[8:5] >= 4'd1 && dos_date[8:5] <= 4'd12
			&& dos_date[4:0] != 5'd0))
		else $error("date word holds an impossible month or day");

	// Every delivered time has hour, minute and half-second in range.
	a_time_fields: assert property (@(posedge clk) disable iff (!arst_n)
		dos_valid |-> (dos_time[15:11] <= 5'd23 && dos_time[10:5] <= 6'd59
			&& dos_time[4:0] <= 5'd29))
		else $error("time word holds an out-of-range field");

	// A beat in the last stage moves out only through a completed output handshake.
	a_no_lost_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s9 && dos_stall) |=> v_s9)
		else $error("output beat dropped while stalled");
`endif

endmodule

// File: sim/epoch_to_dos_datetime_tb.sv
// Self-checking testbench for epoch_to_dos_datetime: epoch second counts in, DOS words out.
// A scoreboard class computes the expected date and time words and checks each output beat.
// Depends only on hdl/epoch_to_dos_datetime.sv and the package that it uses.
module epoch_to_dos_datetime_tb;

	localparam int unsigned SECS_PER_DAY   = 86400;
	localparam int unsigned MARCH0_TO_1970 = 719468;
	localparam int unsigned CYCLE_DAYS     = 146097;
	localparam int unsigned DOS_YEAR0      = 1980;
	localparam int          RANDOM_BEATS   = 1900;
	localparam int          IDLE_PCT       = 22;
	localparam int          CALM_FIRST     = 1100;
	localparam int          CALM_LAST      = 1400;
	localparam int          HOLD_AT        = 400;
	localparam int          HOLD_CYCLES    = 120;
	localparam int          DRAIN_AT       = 800;
	localparam int          STUCK_LIMIT    = 5000;
	localparam int          TAIL_CYCLES    = 30;

	typedef struct packed {
		logic [15:0] date_w;
		logic [15:0] time_w;
	} dos_words_t;

	// Expected DOS words, oldest first, with the conversion that produces them.
	class dos_scoreboard;
		dos_words_t pending_dos[$];
		int         mismatches;

		function new();
			mismatches = 0;
		endfunction

		// Civil calendar from the day count, counted from March 1 so leap days fall last.
		function dos_words_t dos_words_of(logic [31:0] secs);
			int unsigned day_num, sec_of_day, hr, mn, sc;
			int unsigned shifted, cyc, day_in_cyc, yr_in_cyc, day_in_yr;
			int unsigned mar_month, dom, mon, yr;
			dos_words_t w;
			day_num    = secs / SECS_PER_DAY;
			sec_of_day = secs - day_num * SECS_PER_DAY;
			hr         = sec_of_day / 3600;
			mn         = (sec_of_day - hr * 3600) / 60;
			sc         = sec_of_day % 60;
			shifted    = day_num + MARCH0_TO_1970;
			cyc        = shifted / CYCLE_DAYS;
			day_in_cyc = shifted - cyc * CYCLE_DAYS;
			yr_in_cyc  = (day_in_cyc - day_in_cyc / 1460 + day_in_cyc / 36524
				- day_in_cyc / 146096) / 365;
			day_in_yr  = day_in_cyc - (365 * yr_in_cyc + yr_in_cyc / 4 - yr_in_cyc / 100);
			mar_month  = (5 * day_in_yr + 2) / 153;
			dom        = day_in_yr - (153 * mar_month + 2) / 5 + 1;
			mon        = (mar_month < 10) ? mar_month + 3 : mar_month - 9;
			yr         = yr_in_cyc + cyc * 400 + ((mon <= 2) ? 1 : 0);
			// Years before 1980 wrap into the seven-bit field.
			w.date_w = {7'((yr - DOS_YEAR0) & 32'h7f), 4'(mon), 5'(dom)};
			w.time_w = {5'(hr), 6'(mn), 5'(sc / 2)};
			return w;
		endfunction

		function void note_epoch(logic [31:0] secs);
			pending_dos.push_back(dos_words_of(secs));
		endfunction

		function int outstanding();
			return pending_dos.size();
		endfunction

		task report(string what);
			$display("mismatch: %s", what);
			mismatches++;
		endtask

		task check_dos(logic [15:0] date_w, logic [15:0] time_w);
			dos_words_t want;
			if (pending_dos.size() == 0) begin
				report($sformatf("unexpected beat date=%h time=%h", date_w, time_w));
				return;
			end
			want = pending_dos.pop_front();
			if (date_w !== want.date_w)
				report($sformatf("dos_date got %h want %h", date_w, want.date_w));
			if (time_w !== want.time_w)
				report($sformatf("dos_time got %h want %h", time_w, want.time_w));
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        epoch_valid = 1'b0;
	logic        epoch_stall;
	logic [31:0] epoch_seconds = 32'd0;
	logic        dos_valid;
	logic        dos_stall = 1'b0;
	logic [15:0] dos_date;
	logic [15:0] dos_time;

	dos_scoreboard sb = new();
	int            dos_taken = 0;
	int            stuck_cycles = 0;

	epoch_to_dos_datetime dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.epoch_valid  (epoch_valid),
		.epoch_stall  (epoch_stall),
		.epoch_seconds(epoch_seconds),
		.dos_valid    (dos_valid),
		.dos_stall    (dos_stall),
		.dos_date     (dos_date),
		.dos_time     (dos_time)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// Note accepted input beats and check accepted output beats on the same edge.
	always @(posedge clk) begin
		if (arst_n && epoch_valid && !epoch_stall) begin
			sb.note_epoch(epoch_seconds);
		end
		if (arst_n && dos_valid && !dos_stall) begin
			sb.check_dos(dos_date, dos_time);
			dos_taken <= dos_taken + 1;
		end
	end

	// Watchdog: give up once no beat has moved on either side for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((epoch_valid && !epoch_stall) || (dos_valid && !dos_stall))
				stuck_cycles <= 0;
			else
				stuck_cycles <= stuck_cycles + 1;
			if (stuck_cycles >= STUCK_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	function automatic bit calm_window(int n);
		return n >= CALM_FIRST && n <= CALM_LAST;
	endfunction

	// Receiver: random stalls, one long hold-off, and a stretch with no stalls.
	initial begin : receiver
		int hold_left;
		bit held;
		hold_left = 0;
		held = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!held && dos_taken >= HOLD_AT) begin
				held = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				dos_stall <= 1'b1;
				hold_left--;
			end else if (calm_window(dos_taken)) begin
				dos_stall <= 1'b0;
			end else begin
				dos_stall <= ($urandom_range(99) < IDLE_PCT);
			end
		end
	end

	// Offer one epoch beat, with random idle cycles first, and wait until it is taken.
	task automatic send_epoch(input logic [31:0] secs, input int seq);
		while (!calm_window(seq) && $urandom_range(99) < IDLE_PCT) begin
			epoch_valid <= 1'b0;
			@(posedge clk);
		end
		epoch_valid <= 1'b1;
		epoch_seconds <= secs;
		do @(posedge clk); while (epoch_stall);
	endtask

	task automatic wait_drained();
		while (sb.outstanding() > 0) @(posedge clk);
	endtask

	// Random counts: many sit on day edges or around the 2000 leap day, the rest anywhere.
	function automatic logic [31:0] pick_epoch();
		int unsigned day_num;
		int unsigned offs[4] = '{0, 1, 86398, 86399};
		case ($urandom_range(3))
			0: begin
				day_num = $urandom_range(49709);
				return day_num * SECS_PER_DAY + offs[$urandom_range(3)];
			end
			1: return $urandom_range(951868800 + 5 * 86400, 946684800 - 40 * 86400);
			default: return $urandom();
		endcase
	endfunction

	initial begin : stimulus
		logic [31:0] directed_epochs[$];
		int seq;
		directed_epochs = '{
			32'd0, 32'd1, 32'd59, 32'd86399, 32'd86400,
			32'd68169600,                   // leap day 1972
			32'd315532799, 32'd315532800,   // last second before 1980, first of 1980
			32'd946684799, 32'd946684800,   // turn of the century
			32'd951782399, 32'd951782400,   // leap day in a 400-year century
			32'd951868800,
			32'd4107542399, 32'd4107542400, // 2100 skips its leap day
			32'h7fffffff, 32'h80000000, 32'haaaaaaaa, 32'h55555555,
			32'd4294944000, 32'hfffffffe, 32'hffffffff
		};
		seq = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_epochs[i]) begin
			send_epoch(directed_epochs[i], seq);
			seq++;
		end
		epoch_valid <= 1'b0;
		@(posedge clk);
		wait_drained();

		for (int i = 0; i < RANDOM_BEATS; i++) begin
			// Once in the run the sender stops until the pipeline has emptied.
			if (i == DRAIN_AT) begin
				epoch_valid <= 1'b0;
				@(posedge clk);
				wait_drained();
			end
			send_epoch(pick_epoch(), seq);
			seq++;
		end
		epoch_valid <= 1'b0;
		@(posedge clk);

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.mismatches == 0 && sb.outstanding() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

// File: files.f
hdl/e2dd_pkg.sv
hdl/epoch_to_dos_datetime.sv
sim/epoch_to_dos_datetime_tb.sv
